[rtl/core/fpalu_pkg.sv]
`timescale 1ns / 1ps
package fpalu_pkg;

  // Opcodes
  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_SUB      = 4'd1;
  localparam logic [3:0] OP_MUL      = 4'd2;
  localparam logic [3:0] OP_DIV      = 4'd3;
  localparam logic [3:0] OP_GT       = 4'd4;
  localparam logic [3:0] OP_LT       = 4'd5;
  localparam logic [3:0] OP_GE       = 4'd6;
  localparam logic [3:0] OP_LE       = 4'd7;
  localparam logic [3:0] OP_EQ       = 4'd8;
  localparam logic [3:0] OP_NE       = 4'd9;
  localparam logic [3:0] OP_MIN      = 4'd10;
  localparam logic [3:0] OP_MAX      = 4'd11;
  localparam logic [3:0] OP_INC      = 4'd12;
  localparam logic [3:0] OP_DEC      = 4'd13;
  localparam logic [3:0] OP_FROM_INT = 4'd14;
  localparam logic [3:0] OP_TO_INT   = 4'd15;

  localparam int unsigned DATA_W = 32;

  // Per-word info that rides alongside the divider stages
  typedef struct packed {
    logic [DATA_W-1:0] res;     // result of every non-divide op
    logic              cmp;
    logic              is_div;
    logic              neg;     // quotient gets negated
    logic              dz;
  } fpalu_side_t;

endpackage

[rtl/core/fpalu_if.sv]
`timescale 1ns / 1ps
interface fpalu_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         cmd;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source(output valid, cmd, operand_a, operand_b, input ready);
  modport sink(input valid, cmd, operand_a, operand_b, output ready);
endinterface

interface fpalu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               compare_true;
  logic               divide_by_zero;
  modport source(output valid, result_value, compare_true, divide_by_zero, input ready);
  modport sink(input valid, result_value, compare_true, divide_by_zero, output ready);
endinterface

[rtl/core/fixed_point_alu.sv]
`timescale 1ns / 1ps
// Signed 32-bit fixed-point ALU with FRACTION_BITS fraction bits. One word
// is accepted every cycle unless the output stalls, and every word returns
// exactly one result, in order, after passing through one decode/multiply
// stage, one restoring-divider stage per quotient bit (32 + FRACTION_BITS),
// and the output register. All opcodes take that same path. The whole
// pipeline holds while a result waits at the output; in_ready is high
// whenever the output register is empty or being read.
module fixed_point_alu import fpalu_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  fpalu_in_if.sink    in_ch,
  fpalu_out_if.source out_ch
);

  localparam int DW = 32 + FRACTION_BITS;

  logic          adv;
  logic          f_valid;
  logic [DW-1:0] f_num;
  logic [31:0]   f_den;
  fpalu_side_t   f_side;
  logic          d_valid;
  logic [31:0]   d_quot;
  fpalu_side_t   d_side;
  logic          out_valid_r;
  logic [31:0]   res_nxt;
  logic [31:0]   res_r;
  logic          cmp_r;
  logic          dz_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  fpalu_front #(.FRACTION_BITS(FRACTION_BITS), .DW(DW)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .cmd      (in_ch.cmd),
    .operand_a(in_ch.operand_a),
    .operand_b(in_ch.operand_b),
    .valid_r  (f_valid),
    .num_r    (f_num),
    .den_r    (f_den),
    .side_r   (f_side)
  );

  fpalu_div #(.DW(DW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .valid_i(f_valid),
    .num_i  (f_num),
    .den_i  (f_den),
    .side_i (f_side),
    .valid_o(d_valid),
    .quot_o (d_quot),
    .side_o (d_side)
  );

  // Final select: signed quotient for divides, the side result otherwise, zero on divide by zero
  always_comb begin
    if (d_side.dz) begin
      res_nxt = '0;
    end else if (d_side.is_div) begin
      res_nxt = d_side.neg ? 32'(-d_quot) : d_quot;
    end else begin
      res_nxt = d_side.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      cmp_r <= d_side.cmp;
      dz_r  <= d_side.dz;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_value   = res_r;
  assign out_ch.compare_true   = cmp_r;
  assign out_ch.divide_by_zero = dz_r;

endmodule

[rtl/core/fpalu_front.sv]
`timescale 1ns / 1ps
module fpalu_front import fpalu_pkg::*; #(
  parameter int FRACTION_BITS = 8,
  parameter int DW            = 32 + FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [3:0]         cmd,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               valid_r,
  output logic [DW-1:0]      num_r,
  output logic [31:0]        den_r,
  output fpalu_side_t        side_r
);

  logic signed [63:0] prod;
  logic [31:0]        abs_a;
  logic [31:0]        abs_b;
  fpalu_side_t        side_nxt;

  assign prod  = operand_a * operand_b;
  assign abs_a = operand_a[31] ? 32'(-operand_a) : 32'(operand_a);
  assign abs_b = operand_b[31] ? 32'(-operand_b) : 32'(operand_b);

  // Decode and all non-divide ops
  always_comb begin
    side_nxt        = '0;
    side_nxt.is_div = (cmd == OP_DIV);
    side_nxt.neg    = operand_a[31] ^ operand_b[31];
    side_nxt.dz     = (cmd == OP_DIV) && (operand_b == 32'sd0);
    case (cmd)
      OP_ADD:      side_nxt.res = 32'(operand_a + operand_b);
      OP_SUB:      side_nxt.res = 32'(operand_a - operand_b);
      OP_MUL:      side_nxt.res = prod[FRACTION_BITS +: 32];
      OP_GT:       side_nxt.cmp = operand_a > operand_b;
      OP_LT:       side_nxt.cmp = operand_a < operand_b;
      OP_GE:       side_nxt.cmp = operand_a >= operand_b;
      OP_LE:       side_nxt.cmp = operand_a <= operand_b;
      OP_EQ:       side_nxt.cmp = operand_a == operand_b;
      OP_NE:       side_nxt.cmp = operand_a != operand_b;
      OP_MIN:      side_nxt.res = (operand_a < operand_b) ? operand_a : operand_b;
      OP_MAX:      side_nxt.res = (operand_a > operand_b) ? operand_a : operand_b;
      OP_INC:      side_nxt.res = 32'(operand_a + 32'sd1);
      OP_DEC:      side_nxt.res = 32'(operand_a - 32'sd1);
      OP_FROM_INT: side_nxt.res = 32'(operand_a <<< FRACTION_BITS);
      OP_TO_INT:   side_nxt.res = 32'(operand_a >>> FRACTION_BITS);
      default:     side_nxt.res = '0;  // divide finishes in the array
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r  <= DW'(abs_a) << FRACTION_BITS;
      den_r  <= abs_b;
      side_r <= side_nxt;
    end
  end

endmodule

[rtl/core/fpalu_div_step.sv]
`timescale 1ns / 1ps
module fpalu_div_step import fpalu_pkg::*; #(
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          valid_i,
  input  logic [31:0]   rem_i,
  input  logic [DW-1:0] nq_i,
  input  logic [31:0]   den_i,
  input  fpalu_side_t   side_i,
  output logic          valid_r,
  output logic [31:0]   rem_r,
  output logic [DW-1:0] nq_r,
  output logic [31:0]   den_r,
  output fpalu_side_t   side_r
);

  logic [32:0] trial;
  logic        ge;

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign trial = {rem_i, nq_i[DW-1]};
  assign ge    = trial >= {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r  <= ge ? 32'(trial - {1'b0, den_i}) : trial[31:0];
      nq_r   <= {nq_i[DW-2:0], ge};
      den_r  <= den_i;
      side_r <= side_i;
    end
  end

endmodule

[rtl/core/fpalu_div.sv]
`timescale 1ns / 1ps
module fpalu_div import fpalu_pkg::*; #(
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          valid_i,
  input  logic [DW-1:0] num_i,
  input  logic [31:0]   den_i,
  input  fpalu_side_t   side_i,
  output logic          valid_o,
  output logic [31:0]   quot_o,
  output fpalu_side_t   side_o
);

  logic              v   [DW+1];
  logic [31:0]       rem [DW+1];
  logic [DW-1:0]     nq  [DW+1];
  logic [31:0]       den [DW+1];
  fpalu_side_t       sd  [DW+1];

  assign v[0]   = valid_i;
  assign rem[0] = '0;
  assign nq[0]  = num_i;
  assign den[0] = den_i;
  assign sd[0]  = side_i;

  // One quotient bit per stage
  for (genvar i = 0; i < DW; i++) begin : g_step
    fpalu_div_step #(.DW(DW)) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .valid_i(v[i]),
      .rem_i  (rem[i]),
      .nq_i   (nq[i]),
      .den_i  (den[i]),
      .side_i (sd[i]),
      .valid_r(v[i+1]),
      .rem_r  (rem[i+1]),
      .nq_r   (nq[i+1]),
      .den_r  (den[i+1]),
      .side_r (sd[i+1])
    );
  end

  assign valid_o = v[DW];
  assign quot_o  = nq[DW][31:0];
  assign side_o  = sd[DW];

endmodule

[rtl/core/fpalu_chk.sv]
`timescale 1ns / 1ps
module fpalu_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result,
  input logic        out_cmp,
  input logic        out_dz
);

  // A held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed while stalled");

  // Nothing comes out right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");

  // Divide by zero gives a zero value and no compare flag
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dz |-> out_result == 32'd0 && !out_cmp)
    else $error("bad divide-by-zero result");

  // Input is taken whenever the output side is free
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("ready low with empty output");

  // Compare results carry a zero value
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmp |-> out_result == 32'd0)
    else $error("compare with nonzero value");

endmodule

bind fixed_point_alu fpalu_chk u_fpalu_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_result(out_ch.result_value),
  .out_cmp   (out_ch.compare_true),
  .out_dz    (out_ch.divide_by_zero)
);
